### design/mfmt_pkg.sv
// ----------------------------------------------------------------------------
// mfmt_pkg
// Types and constants shared by the multi-turn tracker core and its divider.
// ----------------------------------------------------------------------------
package mfmt_pkg;

  localparam int COUNTS_PER_REV = 8192;
  localparam int ANG_W          = $clog2(COUNTS_PER_REV);
  localparam int TURN_W         = 24;
  localparam int TOTAL_W        = 37;
  localparam int AXIS_W         = 41;
  localparam int ASPD_W         = 24;

  localparam logic [10:0] BASE_ID = 11'h201;
  localparam logic signed [ANG_W:0] HALF_REV = (ANG_W + 1)'(COUNTS_PER_REV / 2);

  // divider: numerator shifted in two bits per cycle
  localparam int NUM_W        = 42;
  localparam int DEN_W        = 10;
  localparam int SPD_NUM_W    = 26;
  localparam int DIGITS_ANGLE = NUM_W / 2;
  localparam int DIGITS_SPEED = SPD_NUM_W / 2;
  localparam int CNT_W        = $clog2(DIGITS_ANGLE + 1);

  localparam logic [1:0] REG_RATIO_HIGH = 2'd0;
  localparam logic [1:0] REG_RATIO_LOW  = 2'd1;
  localparam logic [1:0] REG_TYPE_MASK  = 2'd2;
  localparam logic [1:0] REG_WARMUP     = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_UPD,
    S_TOT,
    S_ABS,
    S_MUL,
    S_SUM,
    S_DA_GO,
    S_DA_WAIT,
    S_DS_GO,
    S_DS_WAIT,
    S_FIN,
    S_OUT
  } state_t;

  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] digits;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

### design/mfmt_div.sv
// ----------------------------------------------------------------------------
// mfmt_div
// Unsigned restoring divider, radix 4: two numerator bits enter per cycle.
// The numerator is left aligned; digits sets how many two-bit steps are run.
// ----------------------------------------------------------------------------
module mfmt_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  mfmt_pkg::div_ctrl_t         ctrl,
  input  logic [mfmt_pkg::NUM_W-1:0]  num,
  input  logic [mfmt_pkg::DEN_W-1:0]  den,
  output mfmt_pkg::div_stat_t         stat,
  output logic [mfmt_pkg::NUM_W-1:0]  quo
);
  import mfmt_pkg::*;

  logic             busy_r;
  logic [CNT_W-1:0] cnt_r;
  logic [NUM_W-1:0] num_r;
  logic [NUM_W-1:0] quo_r;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] rem_nxt;
  logic [DEN_W:0]   r1;
  logic [DEN_W:0]   r1s;
  logic [DEN_W:0]   r2;
  logic [DEN_W:0]   r2s;
  logic             q1;
  logic             q2;

  always_comb begin
    r1  = {rem_r, num_r[NUM_W-1]};
    q1  = r1 >= {1'b0, den_r};
    r1s = q1 ? r1 - {1'b0, den_r} : r1;
    r2  = {r1s[DEN_W-1:0], num_r[NUM_W-2]};
    q2  = r2 >= {1'b0, den_r};
    r2s = q2 ? r2 - {1'b0, den_r} : r2;
    rem_nxt = r2s[DEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (ctrl.start) begin
      busy_r <= 1'b1;
      cnt_r  <= ctrl.digits;
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      num_r <= num;
      den_r <= den;
      rem_r <= '0;
      quo_r <= '0;
    end else if (busy_r) begin
      num_r <= {num_r[NUM_W-3:0], 2'b00};
      rem_r <= rem_nxt;
      quo_r <= {quo_r[NUM_W-3:0], q1, q2};
    end
  end

  assign stat = '{busy: busy_r, done: busy_r && (cnt_r == CNT_W'(1))};
  assign quo  = quo_r;

endmodule

### design/motor_feedback_multiturn_tracker_core.sv
// ----------------------------------------------------------------------------
// motor_feedback_multiturn_tracker_core
// Multi-turn angle unwrap and output-shaft scaling for motor feedback frames.
// ----------------------------------------------------------------------------
// Input stream: one feedback frame per transfer (identifier plus six bytes of
// big-endian angle, speed and current). Output stream: one result per frame.
// Frames with an identifier outside the motor range return status 1 and all
// other fields zero, leaving the per-motor state untouched.
// A valid identifier passes twice through the shared radix-4 divider, first
// for the 42-bit angle quotient and then for the speed quotient; around
// these lie the input transfer, update, sum, magnitude, multiply-by-45, the
// two divider starts, sign restore and output load. A bad identifier goes
// from the update straight to the output load. No new frame is taken until
// the last one has reached the output register.
// A finished result sits in the output register; the next frame is taken
// while it waits, and the core stalls only when a second result is ready
// before the first has been transferred.
// Reset (synchronous, active low) clears all per-motor state and loads the
// register defaults (ratios 100 and 36, type mask 0, warmup 50).
// Configuration is written over the APB port; the user must write it only
// while the core is idle, since the block itself does not enforce this.
// ----------------------------------------------------------------------------
module motor_feedback_multiturn_tracker_core #(
  parameter int MOTORS = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  // tdata: frame_id[10:0], angle_high[18:11], angle_low[26:19],
  //        speed_high[34:27], speed_low[42:35], current_high[50:43],
  //        current_low[58:51], zero[63:59]
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [63:0]   in_tdata,
  // tdata: rotor_counts[12:0], speed_rpm[28:13], current_value[44:29],
  //        turn_count[68:45], rotor_total[105:69], axis_angle_q8[146:106],
  //        axis_speed_q8[170:147], zero[175:171]
  // tuser: status[0], motor_index[3:1], tracking[4]
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [175:0]  out_tdata,
  output logic [4:0]    out_tuser,
  input  logic          cfg_psel,
  input  logic          cfg_penable,
  input  logic          cfg_pwrite,
  input  logic [3:0]    cfg_paddr,
  input  logic [31:0]   cfg_pwdata,
  output logic [31:0]   cfg_prdata,
  output logic          cfg_pready
);
  import mfmt_pkg::*;

  localparam int MOTOR_W = (MOTORS > 1) ? $clog2(MOTORS) : 1;

  // configuration
  logic [7:0] ratio_hi_r;
  logic [7:0] ratio_lo_r;
  logic [7:0] type_r;
  logic [5:0] warm_r;

  // per-motor state
  logic [5:0]        fcnt_r [MOTORS];
  logic [ANG_W-1:0]  last_r [MOTORS];
  logic [ANG_W-1:0]  offs_r [MOTORS];
  logic [TURN_W-1:0] turn_r [MOTORS];
  logic [15:0]       spds_r [MOTORS];
  logic [15:0]       curs_r [MOTORS];

  state_t state_r, state_nxt;

  // frame capture
  logic [10:0] id_r;
  logic [15:0] ang_raw_r;
  logic [15:0] spd_in_r;
  logic [15:0] cur_in_r;

  // update stage
  logic [11:0]        id_off;
  logic               bad_w;
  logic [MOTOR_W-1:0] mi;
  logic [2:0]         mi3;
  logic               trk_w;
  logic [ANG_W-1:0]   angle_w;
  logic signed [ANG_W:0] diff_w;
  logic [5:0]         fcnt_nxt;
  logic [ANG_W-1:0]   last_nxt;
  logic [ANG_W-1:0]   offs_nxt;
  logic [TURN_W-1:0]  turn_nxt;
  logic [15:0]        spds_nxt;
  logic [15:0]        curs_nxt;
  logic [7:0]         ratio_w;

  logic               bad_r;
  logic               trk_r;
  logic [2:0]         m_r;
  logic [ANG_W-1:0]   angle_r;
  logic [ANG_W-1:0]   lastv_r;
  logic [ANG_W-1:0]   offsv_r;
  logic [TURN_W-1:0]  turnv_r;
  logic [15:0]        spdv_r;
  logic [15:0]        curv_r;
  logic [7:0]         ratio_r;

  // arithmetic stages
  logic [ANG_W:0]       dlo;
  logic [TOTAL_W:0]     sum_w;
  logic [TOTAL_W-1:0]   total_w;
  logic [TOTAL_W-1:0]   total_r;
  logic                 tneg_r;
  logic [TOTAL_W-1:0]   tmag_r;
  logic                 sneg_r;
  logic [15:0]          smag_r;
  logic [NUM_W-1:0]     pa_r;
  logic [NUM_W-1:0]     pb_r;
  logic [NUM_W-1:0]     prod_r;
  logic [AXIS_W-1:0]    qa_r;
  logic [AXIS_W-1:0]    axis_r;
  logic [ASPD_W-1:0]    aspd_r;

  // divider
  div_ctrl_t        div_ctrl;
  div_stat_t        div_stat;
  logic [NUM_W-1:0] div_num;
  logic [NUM_W-1:0] div_quo;

  // output register
  logic         out_valid_r;
  logic [175:0] out_data_r;
  logic [4:0]   out_user_r;
  logic         out_free;

  // --------------------------------------------------------------------------
  // configuration port
  // --------------------------------------------------------------------------
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ratio_hi_r <= 8'd100;
      ratio_lo_r <= 8'd36;
      type_r     <= 8'd0;
      warm_r     <= 6'd50;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
      unique case (cfg_paddr[3:2])
        REG_RATIO_HIGH: ratio_hi_r <= cfg_pwdata[7:0];
        REG_RATIO_LOW:  ratio_lo_r <= cfg_pwdata[7:0];
        REG_TYPE_MASK:  type_r     <= cfg_pwdata[7:0];
        REG_WARMUP:     warm_r     <= cfg_pwdata[5:0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_RATIO_HIGH: cfg_prdata = {24'd0, ratio_hi_r};
      REG_RATIO_LOW:  cfg_prdata = {24'd0, ratio_lo_r};
      REG_TYPE_MASK:  cfg_prdata = {24'd0, type_r};
      REG_WARMUP:     cfg_prdata = {26'd0, warm_r};
    endcase
  end

  // --------------------------------------------------------------------------
  // control
  // --------------------------------------------------------------------------
  assign out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:    if (in_tvalid) state_nxt = S_UPD;
      S_UPD:     state_nxt = bad_w ? S_OUT : S_TOT;
      S_TOT:     state_nxt = S_ABS;
      S_ABS:     state_nxt = S_MUL;
      S_MUL:     state_nxt = S_SUM;
      S_SUM:     state_nxt = S_DA_GO;
      S_DA_GO:   state_nxt = S_DA_WAIT;
      S_DA_WAIT: if (div_stat.done) state_nxt = S_DS_GO;
      S_DS_GO:   state_nxt = S_DS_WAIT;
      S_DS_WAIT: if (div_stat.done) state_nxt = S_FIN;
      S_FIN:     state_nxt = S_OUT;
      S_OUT:     if (out_free) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_tready       = 1'b0;
    div_ctrl.start  = 1'b0;
    div_ctrl.digits = CNT_W'(DIGITS_ANGLE);
    div_num         = prod_r;
    unique case (state_r)
      S_IDLE:  in_tready = 1'b1;
      S_DA_GO: div_ctrl.start = 1'b1;
      S_DS_GO: begin
        div_ctrl.start  = 1'b1;
        div_ctrl.digits = CNT_W'(DIGITS_SPEED);
        div_num         = {smag_r, {(NUM_W - 16){1'b0}}};
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // state update
  // --------------------------------------------------------------------------
  always_comb begin
    id_off  = {1'b0, id_r} - {1'b0, BASE_ID};
    bad_w   = id_off[11] || (id_off[10:0] >= 11'(MOTORS));
    mi      = id_off[MOTOR_W-1:0];
    mi3     = 3'(mi);
    angle_w = ang_raw_r[ANG_W-1:0];
    trk_w   = fcnt_r[mi] >= warm_r;
    diff_w  = $signed({1'b0, angle_w}) - $signed({1'b0, last_r[mi]});

    fcnt_nxt = fcnt_r[mi];
    last_nxt = angle_w;
    offs_nxt = offs_r[mi];
    turn_nxt = turn_r[mi];
    spds_nxt = spds_r[mi];
    curs_nxt = curs_r[mi];
    if (!trk_w) begin
      offs_nxt = angle_w;
      fcnt_nxt = fcnt_r[mi] + 6'd1;
    end else begin
      spds_nxt = spd_in_r;
      curs_nxt = cur_in_r;
      if (diff_w > HALF_REV) begin
        if (turn_r[mi] != {1'b1, {(TURN_W - 1){1'b0}}}) turn_nxt = turn_r[mi] - 1'b1;
      end else if (diff_w < -HALF_REV) begin
        if (turn_r[mi] != {1'b0, {(TURN_W - 1){1'b1}}}) turn_nxt = turn_r[mi] + 1'b1;
      end
    end

    ratio_w = type_r[mi3] ? ratio_hi_r : ratio_lo_r;
    if (ratio_w == 8'd0) ratio_w = 8'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MOTORS; i++) begin
        fcnt_r[i] <= '0;
        last_r[i] <= '0;
        offs_r[i] <= '0;
        turn_r[i] <= '0;
        spds_r[i] <= '0;
        curs_r[i] <= '0;
      end
    end else if (state_r == S_UPD && !bad_w) begin
      fcnt_r[mi] <= fcnt_nxt;
      last_r[mi] <= last_nxt;
      offs_r[mi] <= offs_nxt;
      turn_r[mi] <= turn_nxt;
      spds_r[mi] <= spds_nxt;
      curs_r[mi] <= curs_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // datapath
  // --------------------------------------------------------------------------
  always_comb begin
    dlo   = {1'b0, lastv_r} - {1'b0, offsv_r};
    sum_w = {turnv_r[TURN_W-1], turnv_r, {ANG_W{1'b0}}}
            + {{(TOTAL_W - ANG_W){dlo[ANG_W]}}, dlo};
    if (sum_w[TOTAL_W] != sum_w[TOTAL_W-1]) begin
      total_w = sum_w[TOTAL_W] ? {1'b1, {(TOTAL_W - 1){1'b0}}}
                               : {1'b0, {(TOTAL_W - 1){1'b1}}};
    end else begin
      total_w = sum_w[TOTAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      // multi-byte fields arrive high byte first
      S_IDLE: begin
        id_r      <= in_tdata[10:0];
        ang_raw_r <= {in_tdata[18:11], in_tdata[26:19]};
        spd_in_r  <= {in_tdata[34:27], in_tdata[42:35]};
        cur_in_r  <= {in_tdata[50:43], in_tdata[58:51]};
      end
      S_UPD: begin
        bad_r   <= bad_w;
        trk_r   <= trk_w;
        m_r     <= mi3;
        angle_r <= angle_w;
        lastv_r <= last_nxt;
        offsv_r <= offs_nxt;
        turnv_r <= turn_nxt;
        spdv_r  <= spds_nxt;
        curv_r  <= curs_nxt;
        ratio_r <= ratio_w;
      end
      S_TOT: total_r <= total_w;
      S_ABS: begin
        tneg_r <= total_r[TOTAL_W-1];
        tmag_r <= total_r[TOTAL_W-1] ? ~total_r + 1'b1 : total_r;
        sneg_r <= spdv_r[15];
        smag_r <= spdv_r[15] ? ~spdv_r + 1'b1 : spdv_r;
      end
      // |total| * 45 = 32t + 8t + 4t + t
      S_MUL: begin
        pa_r <= {tmag_r, 5'b0} + {2'b0, tmag_r, 3'b0};
        pb_r <= {3'b0, tmag_r, 2'b0} + {5'b0, tmag_r};
      end
      S_SUM:   prod_r <= pa_r + pb_r;
      S_DS_GO: qa_r <= div_quo[AXIS_W-1:0];
      S_FIN: begin
        axis_r <= tneg_r ? ~qa_r + 1'b1 : qa_r;
        aspd_r <= sneg_r ? ~div_quo[ASPD_W-1:0] + 1'b1 : div_quo[ASPD_W-1:0];
      end
      default: ;
    endcase
  end

  // scaled by 4 on both sides: angle divides by 4*ratio, speed*1024 likewise
  mfmt_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (div_ctrl),
    .num   (div_num),
    .den   ({ratio_r, 2'b00}),
    .stat  (div_stat),
    .quo   (div_quo)
  );

  // --------------------------------------------------------------------------
  // output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_OUT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_OUT && out_free) begin
      if (bad_r) begin
        out_data_r <= '0;
        out_user_r <= 5'b00001;
      end else begin
        out_data_r <= {5'b0, aspd_r, axis_r, total_r, turnv_r, curv_r, spdv_r, angle_r};
        out_user_r <= {trk_r, m_r, 1'b0};
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata == '0 && out_tuser[4:1] == '0)
    else $error("bad identifier result carries data");

  a_capture_whole_turns: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] && !out_tuser[4] |-> out_tdata[81:69] == '0)
    else $error("capture phase total not a whole number of turns");

  a_axis_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata[146:106] == '0 ||
                                    out_tdata[146] == out_tdata[105])
    else $error("axis angle sign differs from rotor total");

  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !div_stat.busy)
    else $error("divider busy while core idle");

endmodule

### tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the motor feedback multi-turn tracker core.
// Feedback frames go in over the input stream and each result transfer is
// compared field by field against an in-bench model of the per-motor unwrap,
// turn counting and output-shaft scaling. A short directed table covers bad
// identifiers, half-revolution boundaries, angle wrap, zero and extreme ratios
// and warmup changes; random phases follow under several register settings
// and idling patterns, one of them with a long output hold-off.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import mfmt_pkg::*;

  localparam int    CLK_PERIOD  = 8;
  localparam int    N_MOTORS    = 8;
  localparam int    WDOG_LIMIT  = 20000;
  localparam int    HOLD_CYCLES = 300;
  localparam int    DRAIN_GAP   = 60;
  localparam int    PHASE_ITEMS = 60;
  localparam int    TURN_HI     = 8388607;
  localparam int    TURN_LO     = -8388608;
  localparam longint TOT_HI  = (64'sd1 <<< (TOTAL_W - 1)) - 1;
  localparam longint TOT_LO  = -(64'sd1 <<< (TOTAL_W - 1));
  localparam longint AXIS_HI = (64'sd1 <<< (AXIS_W - 1)) - 1;
  localparam longint AXIS_LO = -(64'sd1 <<< (AXIS_W - 1));

  typedef struct packed {
    logic               status;
    logic [2:0]         motor;
    logic               tracking;
    logic [ANG_W-1:0]   rotor_counts;
    logic [15:0]        speed_rpm;
    logic [15:0]        current_value;
    logic [TURN_W-1:0]  turn_count;
    logic [TOTAL_W-1:0] rotor_total;
    logic [AXIS_W-1:0]  axis_angle;
    logic [ASPD_W-1:0]  axis_speed;
  } fb_result_t;

  typedef enum logic {ROW_FRAME, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t  kind;
    logic [10:0] id;
    logic [15:0] raw;
    logic [15:0] spd;
    logic [15:0] cur;
    logic [1:0]  reg_idx;
    logic [7:0]  reg_val;
    bit          lit;
    fb_result_t  want;
  } stim_row_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [63:0]  in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [175:0] out_tdata;
  logic [4:0]   out_tuser;
  logic         cfg_psel = 1'b0;
  logic         cfg_penable = 1'b0;
  logic         cfg_pwrite = 1'b0;
  logic [3:0]   cfg_paddr = '0;
  logic [31:0]  cfg_pwdata = '0;
  logic [31:0]  cfg_prdata;
  logic         cfg_pready;

  // register shadow
  logic [7:0] cfg_ratio_hi = 8'd100;
  logic [7:0] cfg_ratio_lo = 8'd36;
  logic [7:0] cfg_mask     = 8'd0;
  logic [5:0] cfg_warmup   = 6'd50;

  // per-motor tracker state
  logic [5:0]        warm_cnt [N_MOTORS];
  logic [ANG_W-1:0]  last_ang [N_MOTORS];
  logic [ANG_W-1:0]  ang_off  [N_MOTORS];
  int                turn_cnt [N_MOTORS];
  logic signed [15:0] spd_hold [N_MOTORS];
  logic signed [15:0] cur_hold [N_MOTORS];

  int stim_ang [N_MOTORS];

  fb_result_t pending_q [$];
  stim_row_t  directed [$];

  int fault_cnt = 0;
  int frames_sent = 0;
  int bad_frames = 0;
  int results_seen = 0;
  int tracking_seen = 0;
  int reg_writes = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_token = 0;
  int hold_seen = 0;
  int hold_left = 0;

  motor_feedback_multiturn_tracker_core #(.MOTORS(N_MOTORS)) u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic logic [63:0] pack_frame(logic [10:0] id, logic [15:0] raw,
                                             logic [15:0] spd, logic [15:0] cur);
    return {5'b0, cur[7:0], cur[15:8], spd[7:0], spd[15:8], raw[7:0], raw[15:8], id};
  endfunction

  function automatic fb_result_t predict_frame(logic [63:0] d);
    fb_result_t r;
    logic [10:0] id;
    logic [2:0] m;
    logic [ANG_W-1:0] ang;
    logic [7:0] ratio;
    longint diff, total, axis, aspd;
    bit trk;
    r = '0;
    id = d[10:0];
    if (id < BASE_ID || id > BASE_ID + 11'(N_MOTORS - 1)) begin
      r.status = 1'b1;
      bad_frames++;
      return r;
    end
    m = 3'(id - BASE_ID);
    ang = ANG_W'({d[18:11], d[26:19]});
    trk = (warm_cnt[m] >= cfg_warmup);
    if (!trk) begin
      last_ang[m] = ang;
      ang_off[m] = ang;
      warm_cnt[m] = warm_cnt[m] + 6'd1;
    end else begin
      diff = longint'(ang) - longint'(last_ang[m]);
      if (diff * 2 > COUNTS_PER_REV) begin
        if (turn_cnt[m] > TURN_LO) turn_cnt[m]--;
      end else if (diff * 2 < -COUNTS_PER_REV) begin
        if (turn_cnt[m] < TURN_HI) turn_cnt[m]++;
      end
      last_ang[m] = ang;
      spd_hold[m] = {d[34:27], d[42:35]};
      cur_hold[m] = {d[50:43], d[58:51]};
    end
    ratio = cfg_mask[m] ? cfg_ratio_hi : cfg_ratio_lo;
    if (ratio == 8'd0) ratio = 8'd1;
    total = longint'(turn_cnt[m]) * COUNTS_PER_REV + longint'(last_ang[m])
            - longint'(ang_off[m]);
    if (total > TOT_HI) total = TOT_HI;
    if (total < TOT_LO) total = TOT_LO;
    axis = (total * longint'(360 * 256)) / (longint'(COUNTS_PER_REV) * longint'(ratio));
    if (axis > AXIS_HI) axis = AXIS_HI;
    if (axis < AXIS_LO) axis = AXIS_LO;
    aspd = (longint'(spd_hold[m]) * 256) / longint'(ratio);
    r.motor         = m;
    r.tracking      = trk;
    r.rotor_counts  = ang;
    r.speed_rpm     = spd_hold[m];
    r.current_value = cur_hold[m];
    r.turn_count    = TURN_W'(turn_cnt[m]);
    r.rotor_total   = total[TOTAL_W-1:0];
    r.axis_angle    = axis[AXIS_W-1:0];
    r.axis_speed    = aspd[ASPD_W-1:0];
    return r;
  endfunction

  function automatic logic [15:0] pick_word();
    int sel;
    sel = $urandom_range(0, 99);
    case (sel)
      0, 1, 2, 3: return 16'h8000;
      4, 5, 6, 7: return 16'h7FFF;
      8, 9, 10:   return 16'h0000;
      11, 12, 13: return 16'hFFFF;
      default:    return 16'($urandom);
    endcase
  endfunction

  // mostly valid motors following a random walk, so the unwrap sees realistic
  // steps with a fair share of half-revolution crossings
  function automatic logic [63:0] rand_frame();
    logic [10:0] id;
    logic [15:0] raw;
    int m, step, pick;
    pick = $urandom_range(0, 99);
    if (pick < 12) id = 11'($urandom_range(0, 2047));
    else id = BASE_ID + 11'($urandom_range(0, N_MOTORS - 1));
    raw = 16'($urandom);
    if (id >= BASE_ID && id < BASE_ID + 11'(N_MOTORS)) begin
      m = int'(id - BASE_ID);
      pick = $urandom_range(0, 99);
      if (pick < 65) step = int'($urandom_range(0, 3000));
      else if (pick < 90) step = 4094 + int'($urandom_range(0, 4));
      else step = int'($urandom_range(0, COUNTS_PER_REV - 1));
      if ($urandom_range(0, 1) == 1) step = -step;
      stim_ang[m] = ((stim_ang[m] + step) % COUNTS_PER_REV + COUNTS_PER_REV)
                    % COUNTS_PER_REV;
      raw = 16'(stim_ang[m] + COUNTS_PER_REV * int'($urandom_range(0, 7)));
    end
    return pack_frame(id, raw, pick_word(), pick_word());
  endfunction

  function automatic stim_row_t frame_row(logic [10:0] id, logic [15:0] raw,
                                          logic [15:0] spd, logic [15:0] cur);
    stim_row_t r;
    r = '{kind: ROW_FRAME, id: id, raw: raw, spd: spd, cur: cur,
          reg_idx: '0, reg_val: '0, lit: 1'b0, want: '0};
    return r;
  endfunction

  function automatic stim_row_t bad_row(logic [10:0] id, logic [15:0] raw,
                                        logic [15:0] spd, logic [15:0] cur);
    stim_row_t r;
    r = frame_row(id, raw, spd, cur);
    r.lit = 1'b1;
    r.want.status = 1'b1;
    return r;
  endfunction

  function automatic stim_row_t cfg_row(logic [1:0] idx, logic [7:0] val);
    stim_row_t r;
    r = frame_row('0, '0, '0, '0);
    r.kind = ROW_CFG;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  task automatic set_idling(int mode);
    case (mode)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
      default: begin send_idle_pct = 20; recv_stall_pct = 20; end
    endcase
  endtask

  task automatic send_frame(logic [63:0] d, bit use_lit, fb_result_t lit_want);
    fb_result_t p;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    do @(posedge clk); while (!in_tready);
    p = predict_frame(d);
    pending_q.push_back(use_lit ? lit_want : p);
    frames_sent++;
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_GAP) @(posedge clk);
  endtask

  task automatic reg_write(logic [1:0] idx, logic [7:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= 32'(val);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx)
      REG_RATIO_HIGH: cfg_ratio_hi = val;
      REG_RATIO_LOW:  cfg_ratio_lo = val;
      REG_TYPE_MASK:  cfg_mask = val;
      REG_WARMUP:     cfg_warmup = val[5:0];
      default: ;
    endcase
    reg_writes++;
    @(posedge clk);
  endtask

  task automatic check_result();
    fb_result_t got, want;
    bit bad;
    got.status        = out_tuser[0];
    got.motor         = out_tuser[3:1];
    got.tracking      = out_tuser[4];
    got.rotor_counts  = out_tdata[12:0];
    got.speed_rpm     = out_tdata[28:13];
    got.current_value = out_tdata[44:29];
    got.turn_count    = out_tdata[68:45];
    got.rotor_total   = out_tdata[105:69];
    got.axis_angle    = out_tdata[146:106];
    got.axis_speed    = out_tdata[170:147];
    if (pending_q.size() == 0) begin
      fault_cnt++;
      if (fault_cnt <= 10) $display("%t: result transfer with no frame outstanding", $realtime);
      return;
    end
    want = pending_q.pop_front();
    results_seen++;
    if (got.tracking) tracking_seen++;
    bad = (got.status != want.status) || (got.motor != want.motor)
          || (got.tracking != want.tracking) || (got.rotor_counts != want.rotor_counts)
          || (got.speed_rpm != want.speed_rpm) || (got.current_value != want.current_value)
          || (got.turn_count != want.turn_count) || (got.rotor_total != want.rotor_total)
          || (got.axis_angle != want.axis_angle) || (got.axis_speed != want.axis_speed);
    if (bad) begin
      fault_cnt++;
      if (fault_cnt <= 10) begin
        $display("%t: mismatch on result %0d", $realtime, results_seen);
        $display("  exp st=%0d m=%0d trk=%0d rc=%h spd=%h cur=%h turns=%h tot=%h ang=%h asp=%h",
                 want.status, want.motor, want.tracking, want.rotor_counts, want.speed_rpm,
                 want.current_value, want.turn_count, want.rotor_total, want.axis_angle,
                 want.axis_speed);
        $display("  got st=%0d m=%0d trk=%0d rc=%h spd=%h cur=%h turns=%h tot=%h ang=%h asp=%h",
                 got.status, got.motor, got.tracking, got.rotor_counts, got.speed_rpm,
                 got.current_value, got.turn_count, got.rotor_total, got.axis_angle,
                 got.axis_speed);
      end
    end
  endtask

  // result side: checking, random stalls and the long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) check_result();
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (hold_seen != hold_token) begin
        hold_seen = hold_token;
        hold_left = HOLD_CYCLES;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  initial begin : watchdog
    int idle_run;
    idle_run = 0;
    while (idle_run < WDOG_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_run = 0;
      else idle_run++;
    end
    $display("%t: no transfer for %0d cycles", $realtime, WDOG_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stimulus
    fb_result_t first;
    int ph;
    for (int m = 0; m < N_MOTORS; m++) begin
      warm_cnt[m] = '0;
      last_ang[m] = '0;
      ang_off[m]  = '0;
      turn_cnt[m] = 0;
      spd_hold[m] = '0;
      cur_hold[m] = '0;
      stim_ang[m] = 0;
    end

    // first frame after reset: capture, offset equals angle, totals zero
    first = '0;
    first.rotor_counts = 13'h1234;
    directed.push_back(frame_row(BASE_ID, 16'h1234, 16'h7FFF, 16'h8000));
    directed[0].lit  = 1'b1;
    directed[0].want = first;
    directed.push_back(bad_row(11'h000, 16'h0000, 16'h0000, 16'h0000));
    directed.push_back(bad_row(11'h200, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    directed.push_back(bad_row(11'h209, 16'h1234, 16'h5678, 16'h9ABC));
    directed.push_back(bad_row(11'h7FF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    // warmup dropped to the value the counter has reached
    directed.push_back(cfg_row(REG_WARMUP, 8'd1));
    directed.push_back(frame_row(BASE_ID, 16'h0000, 16'h7FFF, 16'h8000));
    directed.push_back(frame_row(BASE_ID, 16'h1FFF, 16'h8000, 16'h7FFF));
    directed.push_back(frame_row(BASE_ID, 16'hFFFF, 16'hFFFF, 16'h0001));
    // half-revolution boundaries on the last motor
    directed.push_back(frame_row(BASE_ID + 11'd7, 16'hE000, 16'h1234, 16'h5678));
    directed.push_back(frame_row(BASE_ID + 11'd7, 16'h1000, 16'h0001, 16'hFFFF));
    directed.push_back(frame_row(BASE_ID + 11'd7, 16'h0000, 16'h0002, 16'hFFFE));
    directed.push_back(frame_row(BASE_ID + 11'd7, 16'h1001, 16'h0003, 16'hFFFD));
    directed.push_back(frame_row(BASE_ID + 11'd7, 16'h0000, 16'h0004, 16'hFFFC));
    // zero ratio acts as one, then the largest ratio
    directed.push_back(cfg_row(REG_RATIO_HIGH, 8'd0));
    directed.push_back(cfg_row(REG_TYPE_MASK, 8'hFF));
    directed.push_back(frame_row(BASE_ID, 16'h1000, 16'h8000, 16'h0000));
    directed.push_back(frame_row(BASE_ID + 11'd7, 16'h1000, 16'h7FFF, 16'hFFFF));
    directed.push_back(cfg_row(REG_RATIO_LOW, 8'd255));
    directed.push_back(cfg_row(REG_TYPE_MASK, 8'h00));
    directed.push_back(frame_row(BASE_ID, 16'h1000, 16'h8000, 16'h8000));
    directed.push_back(frame_row(BASE_ID + 11'd7, 16'h1000, 16'h7FFF, 16'h7FFF));
    // warmup raised again: motors return to capture
    directed.push_back(cfg_row(REG_WARMUP, 8'd63));
    directed.push_back(frame_row(BASE_ID + 11'd4, 16'h0ABC, 16'h1111, 16'h2222));
    directed.push_back(frame_row(BASE_ID, 16'h1800, 16'h3333, 16'h4444));
    directed.push_back(cfg_row(REG_WARMUP, 8'd0));
    directed.push_back(frame_row(BASE_ID + 11'd4, 16'h1ABC, 16'h5555, 16'h6666));

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_idling(3);
    foreach (directed[i]) begin
      if (directed[i].kind == ROW_CFG) begin
        wait_drained();
        reg_write(directed[i].reg_idx, directed[i].reg_val);
      end else begin
        send_frame(pack_frame(directed[i].id, directed[i].raw, directed[i].spd,
                              directed[i].cur), directed[i].lit, directed[i].want);
      end
    end

    for (ph = 0; ph < 8; ph++) begin
      wait_drained();
      case (ph)
        0: begin
          reg_write(REG_RATIO_HIGH, 8'd255);
          reg_write(REG_RATIO_LOW, 8'd1);
          reg_write(REG_TYPE_MASK, 8'h55);
          reg_write(REG_WARMUP, 8'd0);
        end
        1: begin
          reg_write(REG_RATIO_HIGH, 8'd1);
          reg_write(REG_RATIO_LOW, 8'd255);
          reg_write(REG_TYPE_MASK, 8'hAA);
          reg_write(REG_WARMUP, 8'd63);
        end
        default: begin
          reg_write(REG_RATIO_HIGH, 8'($urandom_range(0, 255)));
          reg_write(REG_RATIO_LOW, 8'($urandom_range(0, 255)));
          reg_write(REG_TYPE_MASK, 8'($urandom_range(0, 255)));
          reg_write(REG_WARMUP, 8'($urandom_range(0, 6)));
        end
      endcase
      set_idling(ph % 4);
      // output held off while frames keep coming, so the core backs up
      if (ph == 0) hold_token++;
      repeat (PHASE_ITEMS) send_frame(rand_frame(), 1'b0, '0);
    end

    wait_drained();
    $display("run covered %0d frames (%0d bad identifiers), %0d results, %0d tracking",
             frames_sent, bad_frames, results_seen, tracking_seen);
    $display("over %0d register writes, four idling patterns and a %0d-cycle output hold-off",
             reg_writes, HOLD_CYCLES);
    if (fault_cnt == 0 && pending_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### motor_feedback_multiturn_tracker_core.f
design/mfmt_pkg.sv
design/mfmt_div.sv
design/motor_feedback_multiturn_tracker_core.sv
tb/sv/testbench.sv
